// ----- hdl/sh24_pkg.sv -----
// ----------------------------------------------------------------------------
// sh24_pkg
// Shared types, constants and the SipRound function of the SipHash-2-4 engine.
// ----------------------------------------------------------------------------
package sh24_pkg;

  // initialization constants
  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

  // finalization marker xored into v2
  localparam logic [63:0] SIP_FIN_XOR = 64'h00000000000000ff;

  localparam logic [3:0] FULL_BYTES = 4'd8;
  localparam logic [7:0] WORD_BYTES = 8'd8;

  // register file
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  // one classified message item
  typedef struct packed {
    logic        start;     // first item of a message: load state from key
    logic        last;      // final item: length block and finalization follow
    logic        has_word;  // a full 8-byte word is absorbed first
    logic [63:0] word;
    logic [63:0] tail;      // padded tail with length in the top byte
  } sh24_cmd_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned s);
    return (x << s) | (x >> (64 - s));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s_in);
    sip_state_t s;
    s = s_in;
    s.v0 = s.v0 + s.v1;
    s.v1 = rotl64(s.v1, 13) ^ s.v0;
    s.v0 = rotl64(s.v0, 32);
    s.v2 = s.v2 + s.v3;
    s.v3 = rotl64(s.v3, 16) ^ s.v2;
    s.v0 = s.v0 + s.v3;
    s.v3 = rotl64(s.v3, 21) ^ s.v0;
    s.v2 = s.v2 + s.v1;
    s.v1 = rotl64(s.v1, 17) ^ s.v2;
    s.v2 = rotl64(s.v2, 32);
    return s;
  endfunction

endpackage

// ----- hdl/sh24_if.sv -----
// ----------------------------------------------------------------------------
// sh24 channel interfaces
// Message word channel and digest channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sh24_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  data_bytes;
  logic        last_word;

  modport source (output valid, output data_word, output data_bytes, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input data_bytes, input last_word,
                output ready);
endinterface

interface sh24_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;

  modport source (output valid, output digest, input ready);
  modport sink (input valid, input digest, output ready);
endinterface

// ----- hdl/sh24_front.sv -----
// ----------------------------------------------------------------------------
// sh24_front
// Accepts message beats, tracks message start and length, builds commands.
// ----------------------------------------------------------------------------
module sh24_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sh24_msg_if.sink            msg_i,
  output logic                push_valid_o,
  output sh24_pkg::sh24_cmd_t push_cmd_o,
  input  logic                push_ready_i
);
  import sh24_pkg::*;

  logic [7:0]  len_q, len_d;
  logic        start_q, start_d;
  logic [3:0]  nbytes;
  logic [7:0]  len_sum;
  logic [63:0] tail_word;
  logic        accept;
  logic        full_last;

  assign msg_i.ready  = push_ready_i;
  assign push_valid_o = msg_i.valid;
  assign accept       = msg_i.valid && push_ready_i;

  always_comb begin
    nbytes = (msg_i.data_bytes > FULL_BYTES) ? FULL_BYTES : msg_i.data_bytes;
    full_last = (nbytes == FULL_BYTES);
    if (msg_i.last_word) begin
      len_sum = len_q + {4'd0, nbytes};
    end else begin
      len_sum = len_q + WORD_BYTES;
    end
    // keep only the valid low bytes
    for (int i = 0; i < 8; i++) begin
      tail_word[8*i +: 8] = (4'(i) < nbytes) ? msg_i.data_word[8*i +: 8] : 8'd0;
    end

    push_cmd_o.start    = start_q;
    push_cmd_o.last     = msg_i.last_word;
    push_cmd_o.has_word = !msg_i.last_word || full_last;
    push_cmd_o.word     = msg_i.data_word;
    push_cmd_o.tail     = {len_sum, full_last ? 56'd0 : tail_word[55:0]};

    start_d = start_q;
    len_d   = len_q;
    if (accept) begin
      start_d = msg_i.last_word;
      len_d   = msg_i.last_word ? 8'd0 : len_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      len_q   <= 8'd0;
    end else begin
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

endmodule

// ----- hdl/sh24_queue.sv -----
// ----------------------------------------------------------------------------
// sh24_queue
// Two-entry command queue between the front and the round engine.
// ----------------------------------------------------------------------------
module sh24_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  sh24_pkg::sh24_cmd_t push_cmd_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output sh24_pkg::sh24_cmd_t pop_cmd_o,
  input  logic                pop_i
);
  import sh24_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sh24_cmd_t           entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hdl/sh24_back.sv -----
// ----------------------------------------------------------------------------
// sh24_back
// Round engine: one SipRound per cycle over commands, stalls on busy digest.
// ----------------------------------------------------------------------------
module sh24_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         key_low_i,
  input  logic [63:0]         key_high_i,
  input  logic                pop_valid_i,
  input  sh24_pkg::sh24_cmd_t pop_cmd_i,
  output logic                pop_o,
  sh24_dig_if.source          dig_o
);
  import sh24_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WORD,
    PH_TAIL,
    PH_FIN
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  rnd_q, rnd_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] digest_q, digest_d;
  sh24_cmd_t   cur_q;
  sip_state_t  v_q;

  sip_state_t  init_state, base, pre, post;
  logic [63:0] m_pre, m_post;
  logic        fin_pre, go, done, out_free;

  assign dig_o.valid  = out_valid_q;
  assign dig_o.digest = digest_q;
  assign out_free     = !out_valid_q || dig_o.ready;

  always_comb begin
    init_state.v0 = SIP_C0 ^ key_low_i;
    init_state.v1 = SIP_C1 ^ key_high_i;
    init_state.v2 = SIP_C2 ^ key_low_i;
    init_state.v3 = SIP_C3 ^ key_high_i;

    base    = v_q;
    m_pre   = '0;
    m_post  = '0;
    fin_pre = 1'b0;
    go      = 1'b0;
    done    = 1'b0;
    pop_o   = 1'b0;
    phase_d = phase_q;
    rnd_d   = rnd_q;

    case (phase_q)
      PH_IDLE: begin
        // first round of the next command runs in the pop cycle
        if (pop_valid_i) begin
          go    = 1'b1;
          pop_o = 1'b1;
          if (pop_cmd_i.start) begin
            base = init_state;
          end
          m_pre   = pop_cmd_i.has_word ? pop_cmd_i.word : pop_cmd_i.tail;
          phase_d = pop_cmd_i.has_word ? PH_WORD : PH_TAIL;
          rnd_d   = 2'd1;
        end
      end
      PH_WORD: begin
        go      = 1'b1;
        m_post  = cur_q.word;
        phase_d = cur_q.last ? PH_TAIL : PH_IDLE;
        rnd_d   = 2'd0;
      end
      PH_TAIL: begin
        go = 1'b1;
        if (rnd_q == 2'd0) begin
          m_pre = cur_q.tail;
          rnd_d = 2'd1;
        end else begin
          m_post  = cur_q.tail;
          phase_d = PH_FIN;
          rnd_d   = 2'd0;
        end
      end
      PH_FIN: begin
        fin_pre = (rnd_q == 2'd0);
        if (rnd_q == 2'd3) begin
          // hold the last round until the digest register is free
          if (out_free) begin
            go      = 1'b1;
            done    = 1'b1;
            phase_d = PH_IDLE;
            rnd_d   = 2'd0;
          end
        end else begin
          go    = 1'b1;
          rnd_d = rnd_q + 2'd1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        rnd_d   = 2'd0;
      end
    endcase

    pre    = base;
    pre.v3 = pre.v3 ^ m_pre;
    if (fin_pre) begin
      pre.v2 = pre.v2 ^ SIP_FIN_XOR;
    end
    post    = sip_round(pre);
    post.v0 = post.v0 ^ m_post;

    digest_d = digest_q;
    if (done) begin
      digest_d = post.v0 ^ post.v1 ^ post.v2 ^ post.v3;
    end

    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (dig_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      rnd_q       <= 2'd0;
      out_valid_q <= 1'b0;
      digest_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
      digest_q    <= digest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_cmd_i;
    end
    if (go) begin
      v_q <= post;
    end
  end

endmodule

// ----- hdl/siphash_2_4_engine_core.sv -----
// ----------------------------------------------------------------------------
// siphash_2_4_engine_core
// Keyed SipHash-2-4, 64-bit digest, over little-endian 64-bit message beats.
// ----------------------------------------------------------------------------
//   channel  dir  handshake       payload
//   msg_i    in   valid/ready     data_word[63:0], data_bytes[3:0], last_word
//   dig_o    out  valid/ready     digest[63:0]
//   apb      in   psel/penable    paddr[3:0], pwdata[63:0], prdata[63:0]
//
// one SipRound per cycle in a single shared round unit, held on a full digest
// register: word beats run their rounds, last beats also the tail block and
// finalization, then the digest is registered. the hash state is not reset but
// loaded from the key at every message start. a two-entry command queue lets
// the input side keep taking beats while the round unit or the digest stalls.
// ----------------------------------------------------------------------------
module siphash_2_4_engine_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sh24_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sh24_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sh24_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  sh24_msg_if.sink                          msg_i,
  sh24_dig_if.source                        dig_o
);
  import sh24_pkg::*;

  logic [63:0] key_low_q, key_high_q;
  logic        reg_sel;
  logic        wr_en;

  logic        push_valid, push_ready;
  sh24_cmd_t   push_cmd;
  logic        pop_valid, pop;
  sh24_cmd_t   pop_cmd;

  // registers at 8-byte spacing, low address bits ignored
  assign reg_sel = paddr[3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign prdata  = (reg_sel == REG_KEY_HIGH) ? key_high_q : key_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_KEY_LOW) begin
        key_low_q <= pwdata;
      end else begin
        key_high_q <= pwdata;
      end
    end
  end

  sh24_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg_i        (msg_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  sh24_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  sh24_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_o       (pop),
    .dig_o       (dig_o)
  );

endmodule
